[sv/mvna_pkg.sv]
// Package: shared types and constants for the vertex normal accumulator.
package mvna_pkg;

   localparam int unsigned SUM_W   = 24;
   localparam int unsigned NORM_W  = 16;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned IN_W    = 16;
   localparam int unsigned VCNT_W  = 11;
   localparam int unsigned MAG_W   = 30;
   localparam int unsigned SQ_W    = 63;
   localparam int unsigned DIV_W   = 46;
   localparam int unsigned QUO_W   = 15;
   localparam int unsigned MUL_W   = 32;
   localparam int unsigned FRAC_W  = 14;
   localparam int unsigned ONE_Q14 = 16384;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TRI   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_DEGEN = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_POS_RD,
      ST_CROSS,
      ST_SUM_RD,
      ST_ABS,
      ST_SHIFT,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [9:0]         index_a;
      logic [9:0]         index_b;
      logic [9:0]         index_c;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      status_type         status;
   } rsp_type;

endpackage

[sv/mvna_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mvna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mesh_vertex_normal_accumulate_core.sv]
// Top level: smooth vertex normal accumulator with shared iterative arithmetic.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid req_ready req_payload| in        | one command transaction
//   rsp     | rsp_valid rsp_ready rsp_payload| out       | one result per command
//   csr     | csr_valid csr_ready csr_data   | in        | vertex_count write
//
// Load and out-of-range commands answer straight from decode; clear first walks every entry.
// A read and a triangle normalize a vector, the triangle with at most 3 normalizing shifts
// with 16-bit coordinates, then a bit-serial square root and three divides; a zero-length
// vector ends right after the root.
// After reset a clearing pass zeroes every sum entry; req_ready is low meanwhile.
// req_ready is high only while idle; a finished result waits in the output register
// while the next transaction is taken.
module mesh_vertex_normal_accumulate_core #(
   parameter int VERTEX_DEPTH = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mvna_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mvna_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);
   import mvna_pkg::*;

   localparam int AW    = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int CW    = COORD_BITS;
   localparam int VEC_W = (2 * COORD_BITS + 3 > 31) ? 2 * COORD_BITS + 3 : 31;
   localparam int POS_W = 3 * COORD_BITS;
   localparam int SUMS_W = 3 * SUM_W;

   // control
   state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [1:0]    comp_ff, comp_in;
   logic          boot_ff, boot_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [VCNT_W-1:0] vcount_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   status_type    status_ff, status_in;
   logic signed [CW-1:0]    pa_ff [3];
   logic signed [CW-1:0]    pa_in [3];
   logic signed [CW:0]      e1_ff [3];
   logic signed [CW:0]      e1_in [3];
   logic signed [CW:0]      e2_ff [3];
   logic signed [CW:0]      e2_in [3];
   logic signed [2*MUL_W-1:0] prod_ff, prod_in;
   logic signed [VEC_W-1:0] vec_ff [3];
   logic signed [VEC_W-1:0] vec_in [3];
   logic [VEC_W-1:0]        m_ff [3];
   logic [VEC_W-1:0]        m_in [3];
   logic [2:0]              neg_ff, neg_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [SQ_W-1:0]         root_ff, root_in;
   logic [SQ_W-1:0]         bit_ff, bit_in;
   logic [DIV_W-1:0]        drem_ff, drem_in;
   logic [DIV_W-1:0]        dvs_ff, dvs_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic signed [NORM_W-1:0] nrm_ff [3];
   logic signed [NORM_W-1:0] nrm_in [3];

   // memories
   logic              pos_wr_en;
   logic [AW-1:0]     pos_wr_addr, pos_rd_addr;
   logic [POS_W-1:0]  pos_wr_data, pos_rd_data;
   logic              sum_wr_en;
   logic [AW-1:0]     sum_wr_addr, sum_rd_addr;
   logic [SUMS_W-1:0] sum_wr_data, sum_rd_data;

   // shared multiplier
   logic signed [MUL_W-1:0] mul_a, mul_b;

   // misc
   logic          idx_a_ok, idx_b_ok, idx_c_ok;
   logic [AW-1:0] addr_a, addr_b, addr_c, acc_addr;
   logic          acc_cycle_wr;
   logic [SQ_W-1:0] root_try;
   logic          big_mag;
   logic [30:0]   len;
   logic signed [CW-1:0] pos_rd [3];
   logic signed [SUM_W-1:0] sum_rd [3];

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                   input logic [VCNT_W-1:0] vc);
      idx_ok = (32'(idx) < 32'(vc)) && (32'(idx) < 32'(VERTEX_DEPTH));
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [AW+IDX_W-1:0] wide;
      wide = {{AW{1'b0}}, idx};
      to_addr = wide[AW-1:0];
   endfunction

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [IN_W-1:0] raw);
      logic signed [31:0] v;
      logic signed [31:0] lim;
      v   = 32'(raw);
      lim = 32'sd1 <<< (CW - 1);
      if (v > lim - 32'sd1) begin
         v = lim - 32'sd1;
      end else if (v < -lim) begin
         v = -lim;
      end
      sat_coord = CW'(v);
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [NORM_W-1:0] n);
      logic signed [SUM_W:0] t;
      t = (SUM_W + 1)'(s) + (SUM_W + 1)'(n);
      if (t > (SUM_W + 1)'(signed'({1'b0, {(SUM_W - 1){1'b1}}}))) begin
         sat_sum = {1'b0, {(SUM_W - 1){1'b1}}};
      end else if (t < -(SUM_W + 1)'(signed'({2'b01, {(SUM_W - 1){1'b0}}}))) begin
         sat_sum = {1'b1, {(SUM_W - 1){1'b0}}};
      end else begin
         sat_sum = t[SUM_W-1:0];
      end
   endfunction

   mvna_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (pos_wr_addr),
      .wr_data (pos_wr_data),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   mvna_ram #(.WIDTH(SUMS_W), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rd_data)
   );

   // decode indices and unpack memory words
   always_comb begin
      idx_a_ok = idx_ok(req_ff.index_a, vcount_ff);
      idx_b_ok = idx_ok(req_ff.index_b, vcount_ff);
      idx_c_ok = idx_ok(req_ff.index_c, vcount_ff);
      addr_a   = to_addr(req_ff.index_a);
      addr_b   = to_addr(req_ff.index_b);
      addr_c   = to_addr(req_ff.index_c);
      case (cnt_ff[2:1])
         2'd0:    acc_addr = addr_a;
         2'd1:    acc_addr = addr_b;
         default: acc_addr = addr_c;
      endcase
      acc_cycle_wr = cnt_ff[0];
      for (int k = 0; k < 3; k++) begin
         pos_rd[k] = pos_rd_data[k*CW +: CW];
         sum_rd[k] = sum_rd_data[k*SUM_W +: SUM_W];
      end
      root_try = root_ff + bit_ff;
      big_mag  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (m_ff[k][VEC_W-1:MAG_W] != '0) begin
            big_mag = 1'b1;
         end
      end
      len = root_ff[30:0];
   end

   // select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CROSS) begin
         case (cnt_ff)
            6'd0:    begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[2]); end
            6'd1:    begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[1]); end
            6'd2:    begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[0]); end
            6'd3:    begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[2]); end
            6'd4:    begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[1]); end
            6'd5:    begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQUARE && cnt_ff < 6'd3) begin
         mul_a = signed'({2'b00, m_ff[cnt_ff[1:0]][MAG_W-1:0]});
         mul_b = mul_a;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(VERTEX_DEPTH - 1)) begin
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (req_ff.cmd)
               CMD_CLEAR: state_in = ST_CLEAR;
               CMD_LOAD:  state_in = ST_DONE;
               CMD_TRI:   state_in = (idx_a_ok && idx_b_ok && idx_c_ok) ? ST_POS_RD : ST_DONE;
               default:   state_in = idx_a_ok ? ST_SUM_RD : ST_DONE;
            endcase
         end
         ST_POS_RD: if (cnt_ff == 6'd3) state_in = ST_CROSS;
         ST_CROSS:  if (cnt_ff == 6'd6) state_in = ST_ABS;
         ST_SUM_RD: if (cnt_ff == 6'd1) state_in = ST_ABS;
         ST_ABS:    state_in = ST_SHIFT;
         ST_SHIFT:  if (!big_mag) state_in = ST_SQUARE;
         ST_SQUARE: if (cnt_ff == 6'd3) state_in = ST_SQRT;
         ST_SQRT: begin
            if (cnt_ff == 6'd32) begin
               state_in = (len == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == 6'd16 && comp_ff == 2'd2) begin
               state_in = (req_ff.cmd == CMD_TRI) ? ST_ACC : ST_DONE;
            end
         end
         ST_ACC: if (cnt_ff == 6'd5) state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in       = cnt_ff + 6'd1;
      comp_in      = comp_ff;
      boot_in      = boot_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      status_in    = status_ff;
      pa_in        = pa_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      prod_in      = mul_a * mul_b;
      vec_in       = vec_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      drem_in      = drem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      nrm_in       = nrm_ff;
      pos_wr_en    = 1'b0;
      pos_wr_addr  = addr_a;
      pos_wr_data  = {sat_coord(req_ff.coord_z), sat_coord(req_ff.coord_y),
                      sat_coord(req_ff.coord_x)};
      pos_rd_addr  = addr_a;
      sum_wr_en    = 1'b0;
      sum_wr_addr  = clr_ff;
      sum_wr_data  = '0;
      sum_rd_addr  = addr_a;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            sum_wr_en = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(VERTEX_DEPTH - 1)) begin
               clr_in  = '0;
               boot_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_in = req_payload;
            cnt_in = '0;
         end
         ST_DECODE: begin
            cnt_in    = '0;
            comp_in   = '0;
            status_in = STS_OK;
            for (int k = 0; k < 3; k++) nrm_in[k] = '0;
            case (req_ff.cmd)
               CMD_CLEAR: begin
               end
               CMD_LOAD: begin
                  if (idx_a_ok) pos_wr_en = 1'b1;
                  else status_in = STS_RANGE;
               end
               CMD_TRI: begin
                  if (!(idx_a_ok && idx_b_ok && idx_c_ok)) status_in = STS_RANGE;
               end
               default: begin
                  if (!idx_a_ok) status_in = STS_RANGE;
               end
            endcase
         end
         ST_POS_RD: begin
            case (cnt_ff)
               6'd0:    pos_rd_addr = addr_a;
               6'd1:    pos_rd_addr = addr_b;
               default: pos_rd_addr = addr_c;
            endcase
            for (int k = 0; k < 3; k++) begin
               if (cnt_ff == 6'd1) pa_in[k] = pos_rd[k];
               if (cnt_ff == 6'd2) e1_in[k] = (CW + 1)'(pos_rd[k]) - (CW + 1)'(pa_ff[k]);
               if (cnt_ff == 6'd3) e2_in[k] = (CW + 1)'(pos_rd[k]) - (CW + 1)'(pa_ff[k]);
            end
            if (cnt_ff == 6'd3) cnt_in = '0;
         end
         ST_CROSS: begin
            // load the registered product into its component, or subtract it
            case (cnt_ff)
               6'd1:    vec_in[0] = VEC_W'(prod_ff);
               6'd2:    vec_in[0] = vec_ff[0] - VEC_W'(prod_ff);
               6'd3:    vec_in[1] = VEC_W'(prod_ff);
               6'd4:    vec_in[1] = vec_ff[1] - VEC_W'(prod_ff);
               6'd5:    vec_in[2] = VEC_W'(prod_ff);
               6'd6:    vec_in[2] = vec_ff[2] - VEC_W'(prod_ff);
               default: vec_in[0] = vec_ff[0];
            endcase
         end
         ST_SUM_RD: begin
            sum_rd_addr = addr_a;
            if (cnt_ff == 6'd1) begin
               for (int k = 0; k < 3; k++) vec_in[k] = VEC_W'(sum_rd[k]);
            end
         end
         ST_ABS: begin
            for (int k = 0; k < 3; k++) begin
               neg_in[k] = vec_ff[k][VEC_W-1];
               m_in[k]   = vec_ff[k][VEC_W-1] ? VEC_W'(-vec_ff[k]) : VEC_W'(vec_ff[k]);
            end
         end
         ST_SHIFT: begin
            cnt_in = '0;
            sq_in  = '0;
            if (big_mag) begin
               for (int k = 0; k < 3; k++) m_in[k] = m_ff[k] >> 1;
            end
         end
         ST_SQUARE: begin
            if (cnt_ff != 6'd0) sq_in = sq_ff + SQ_W'(prod_ff);
            if (cnt_ff == 6'd3) begin
               cnt_in  = '0;
               root_in = '0;
               bit_in  = SQ_W'(1) << (SQ_W - 1);
            end
         end
         ST_SQRT: begin
            // one digit of the root per cycle
            if (cnt_ff == 6'd0) begin
               sq_in = sq_ff;
            end
            if (cnt_ff != 6'd32) begin
               if (sq_ff >= root_try) begin
                  sq_in   = sq_ff - root_try;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               cnt_in = '0;
               if (len == '0) status_in = STS_DEGEN;
            end
         end
         ST_DIV: begin
            if (cnt_ff == 6'd0) begin
               drem_in = {2'b00, m_ff[comp_ff][MAG_W-1:0], {FRAC_W{1'b0}}}
                         + DIV_W'(len >> 1);
               dvs_in  = DIV_W'(len) << FRAC_W;
               quo_in  = '0;
            end else if (cnt_ff != 6'd16) begin
               if (drem_ff >= dvs_ff) begin
                  drem_in = drem_ff - dvs_ff;
                  quo_in  = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in  = {quo_ff[QUO_W-2:0], 1'b0};
               end
               dvs_in = dvs_ff >> 1;
            end else begin
               // cap, sign and store the component
               if (quo_ff > QUO_W'(ONE_Q14)) begin
                  nrm_in[comp_ff] = NORM_W'(ONE_Q14);
               end else begin
                  nrm_in[comp_ff] = NORM_W'(quo_ff);
               end
               if (neg_ff[comp_ff]) begin
                  nrm_in[comp_ff] = -((quo_ff > QUO_W'(ONE_Q14)) ? NORM_W'(ONE_Q14)
                                                                 : NORM_W'(quo_ff));
               end
               cnt_in  = '0;
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_ACC: begin
            sum_rd_addr = acc_addr;
            sum_wr_addr = acc_addr;
            sum_wr_data = {sat_sum(sum_rd[2], nrm_ff[2]), sat_sum(sum_rd[1], nrm_ff[1]),
                           sat_sum(sum_rd[0], nrm_ff[0])};
            sum_wr_en   = acc_cycle_wr;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.normal_x  = nrm_ff[0];
               rsp_in.normal_y  = nrm_ff[1];
               rsp_in.normal_z  = nrm_ff[2];
               rsp_in.status    = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            vcount_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      pa_ff     <= pa_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      prod_ff   <= prod_in;
      vec_ff    <= vec_in;
      m_ff      <= m_in;
      neg_ff    <= neg_in;
      sq_ff     <= sq_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      drem_ff   <= drem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      nrm_ff    <= nrm_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
